// ----- sv/assert_macros.svh -----
// Assertion helper macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- sv/bts_pkg.sv -----
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types and constants for the bilinear texel sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package bts_pkg;
  localparam int StoreDepth = 65536;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int MaxDim     = 1024;
  localparam int DimW       = 11;
  localparam int IdxW       = 10;   // index bits below MaxDim
  localparam int QueueDepth = 4;
  localparam int QPtrW      = 2;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_TEX_WIDTH  = 1'b0,
    REG_TEX_HEIGHT = 1'b1
  } reg_e;

  typedef struct packed {
    logic               cmd;
    logic [15:0]        texel_index;
    logic [15:0]        texel_red;
    logic [15:0]        texel_green;
    logic [15:0]        texel_blue;
    logic signed [31:0] coord_u;
    logic signed [31:0] coord_v;
  } req_t;

  typedef struct packed {
    logic [15:0] sample_red;
    logic [15:0] sample_green;
    logic [15:0] sample_blue;
  } rsp_t;

  // Classified operation passed from front to back
  typedef struct packed {
    logic             is_sample;
    logic [AddrW-1:0] addr0;   // load address or first fetch
    logic [AddrW-1:0] addr1;
    logic [AddrW-1:0] addr2;
    logic [AddrW-1:0] addr3;
    logic [47:0]      texel;
    logic [15:0]      au;
    logic [16:0]      av;
  } op_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_SCALE,
    FS_ADDR
  } front_state_e;
endpackage

// ----- sv/bilinear_texel_sampler.sv -----
// ----------------------------------------------------------------------------
// bilinear_texel_sampler
// Texel store with a repeat-wrapped bilinear sampler.
// ----------------------------------------------------------------------------
// A load request passes the front (capture, address) and writes one texel
// in the back; it returns nothing. A sample request passes the front
// (capture, scale, address) and in the back reads four texels, one per
// fetch, from the single-port texel store; the back can start the next
// sample on the last fetch of the one before. The back holds up to two
// results; it stops taking work while two samples are started and not yet
// delivered, and while it fetches, but for a sample on its last fetch. The
// store has no reset; load every texel before sampling it.
`timescale 1ns / 1ps
module bilinear_texel_sampler import bts_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [DimW-1:0] cfg_data_i,
  input  req_t            req_i,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  output rsp_t            rsp_o,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i
);
  logic [DimW-1:0] tex_width_q, tex_height_q;
  op_t  f_op, q_op;
  logic f_v, f_r, q_v, q_r;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_width_q  <= DimW'(256);
      tex_height_q <= DimW'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TEX_WIDTH:  tex_width_q  <= cfg_data_i;
        REG_TEX_HEIGHT: tex_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bts_front u_front (
    .clk_i, .rst_ni, .dim_w_i(tex_width_q), .dim_h_i(tex_height_q),
    .req_i, .req_valid_i, .req_ready_o,
    .op_o(f_op), .op_valid_o(f_v), .op_ready_i(f_r)
  );

  bts_queue u_queue (
    .clk_i, .rst_ni, .in_i(f_op), .in_valid_i(f_v), .in_ready_o(f_r),
    .out_o(q_op), .out_valid_o(q_v), .out_ready_i(q_r)
  );

  bts_back u_back (
    .clk_i, .rst_ni, .op_i(q_op), .op_valid_i(q_v), .op_ready_o(q_r),
    .rsp_o, .rsp_valid_o, .rsp_ready_i
  );
endmodule

// ----- sv/bts_front.sv -----
// ----------------------------------------------------------------------------
// bts_front
// Accepts requests, scales and wraps sample coordinates, forms the four fetch
// addresses or the load address, and queues a classified operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bts_front import bts_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [DimW-1:0] dim_w_i,
  input  logic [DimW-1:0] dim_h_i,
  input  req_t            req_i,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  output op_t             op_o,
  output logic            op_valid_o,
  input  logic            op_ready_i
);
  front_state_e state_q, state_d;
  req_t         req_q;
  logic [26:0]  su_q, sv_q;
  logic [DimW-1:0] w_q, h_q;
  logic [IdxW:0] x1, x2, y1, y2;
  logic [IdxW:0] iu, iv, iu1, iv1;
  logic [DimW-1:0] w_eff, h_eff;
  logic [AddrW+DimW:0] p1, p2;
  logic [16:0] fv;

  // Clamp sizes into 1..MaxDim
  always_comb begin
    w_eff = dim_w_i;
    h_eff = dim_h_i;
    if (dim_w_i == '0) w_eff = DimW'(1);
    else if (dim_w_i > DimW'(MaxDim)) w_eff = DimW'(MaxDim);
    if (dim_h_i == '0) h_eff = DimW'(1);
    else if (dim_h_i > DimW'(MaxDim)) h_eff = DimW'(MaxDim);
  end

  assign fv = 17'h10000 - {1'b0, req_q.coord_v[15:0]};

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FS_IDLE: if (req_valid_i) begin
        state_d = (req_i.cmd == CMD_SAMPLE) ? FS_SCALE : FS_ADDR;
      end
      FS_SCALE: state_d = FS_ADDR;
      FS_ADDR:  if (op_ready_i) state_d = FS_IDLE;
      default:  state_d = FS_IDLE;
    endcase
  end

  assign req_ready_o = (state_q == FS_IDLE);

  // Integer parts and wrapped neighbours; iu <= W, iv <= H
  assign iu  = su_q[26:16];
  assign iv  = sv_q[26:16];
  assign x1  = (iu  >= w_q) ? iu  - w_q : iu;
  assign y1  = (iv  >= h_q) ? iv  - h_q : iv;
  // Step from the wrapped index so a size of one stays on index zero
  assign iu1 = x1 + 1'b1;
  assign iv1 = y1 + 1'b1;
  assign x2  = (iu1 == w_q) ? '0 : iu1;
  assign y2  = (iv1 == h_q) ? '0 : iv1;
  assign p1  = (AddrW+DimW+1)'(y1) * (AddrW+DimW+1)'(w_q);
  assign p2  = (AddrW+DimW+1)'(y2) * (AddrW+DimW+1)'(w_q);

  // Outputs
  always_comb begin
    op_valid_o   = (state_q == FS_ADDR);
    op_o.is_sample = req_q.cmd;
    op_o.texel   = {req_q.texel_red, req_q.texel_green, req_q.texel_blue};
    op_o.au      = su_q[15:0];
    op_o.av      = {1'b0, sv_q[15:0]};
    if (req_q.cmd == CMD_SAMPLE) begin
      op_o.addr0 = AddrW'(p1 + (AddrW+DimW+1)'(x1));
      op_o.addr1 = AddrW'(p1 + (AddrW+DimW+1)'(x2));
      op_o.addr2 = AddrW'(p2 + (AddrW+DimW+1)'(x1));
      op_o.addr3 = AddrW'(p2 + (AddrW+DimW+1)'(x2));
    end else begin
      op_o.addr0 = AddrW'(req_q.texel_index);
      op_o.addr1 = '0;
      op_o.addr2 = '0;
      op_o.addr3 = '0;
    end
  end

  // State register; the request capture and scaling follow below
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FS_IDLE && req_valid_i) begin
      req_q <= req_i;
      w_q   <= w_eff;
      h_q   <= h_eff;
    end
    if (state_q == FS_SCALE) begin
      su_q <= 27'({1'b0, req_q.coord_u[15:0]}) * 27'(w_q);
      sv_q <= 27'(fv) * 27'(h_q);
    end
  end
endmodule

// ----- sv/bts_queue.sv -----
// ----------------------------------------------------------------------------
// bts_queue
// Short FIFO of classified operations between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bts_queue import bts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  op_t  in_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  output op_t  out_o,
  output logic out_valid_o,
  input  logic out_ready_i
);
  op_t            mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;
  logic push, pop;

  assign in_ready_o  = (cnt_q != (QPtrW+1)'(QueueDepth));
  assign out_valid_o = (cnt_q != '0);
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;
  assign out_o = mem_q[rd_q];

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_i;
  end
endmodule

// ----- sv/bts_back.sv -----
// ----------------------------------------------------------------------------
// bts_back
// Owns the texel store: performs loads, fetches four texels per sample and
// accumulates the weighted sum one texel a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bts_back import bts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  op_t  op_i,
  input  logic op_valid_i,
  output logic op_ready_o,
  output rsp_t rsp_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i
);
  logic [47:0] store_q [StoreDepth];
  logic [47:0] rd_q;
  op_t         op_q;
  logic        busy_q;
  logic [1:0]  fcnt_q;           // fetch number issued
  logic        rv_q;             // read data valid
  logic [1:0]  rk_q;             // which texel rd_q holds
  logic [32:0] wt_q;             // weight of the texel in rd_q
  logic [49:0] acc_q [3];
  logic        done_q;
  rsp_t        res_q [2];        // two-entry result buffer
  logic        res_wr_q, res_rd_q;
  logic [1:0]  res_cnt_q;
  logic [1:0]  cred_q;           // samples started and not yet delivered
  logic [16:0] au_n, au_c, av_n, av_c;
  logic [33:0] wsel;
  logic [AddrW-1:0] raddr;
  logic        start, start_s, last, pop;

  assign au_c = {1'b0, op_q.au};
  assign au_n = 17'h10000 - au_c;
  assign av_c = op_q.av;
  assign av_n = 17'h10000 - av_c;

  // Take work while a result slot is free; a sample may follow the last fetch
  assign last  = busy_q && fcnt_q == 2'd3;
  assign op_ready_o = (cred_q != 2'd2) && (!busy_q || (last && op_i.is_sample));
  assign start = op_valid_i && op_ready_o;
  assign start_s = start && op_i.is_sample;
  assign pop   = (res_cnt_q != 2'd0) && rsp_ready_i;

  always_comb begin
    unique case (fcnt_q)
      2'd0: begin raddr = op_q.addr0; wsel = au_n * av_n; end
      2'd1: begin raddr = op_q.addr1; wsel = au_c * av_n; end
      2'd2: begin raddr = op_q.addr2; wsel = au_n * av_c; end
      default: begin raddr = op_q.addr3; wsel = au_c * av_c; end
    endcase
  end

  // Sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; fcnt_q <= '0; rv_q <= 1'b0; done_q <= 1'b0;
      rk_q <= '0; res_wr_q <= 1'b0; res_rd_q <= 1'b0;
      res_cnt_q <= '0; cred_q <= '0;
    end else begin
      if (start_s) begin
        busy_q <= 1'b1; fcnt_q <= '0;
      end else if (busy_q) begin
        fcnt_q <= fcnt_q + 1'b1;
        if (last) busy_q <= 1'b0;
      end
      rv_q   <= busy_q;
      rk_q   <= fcnt_q;
      done_q <= rv_q && rk_q == 2'd3;
      if (done_q) res_wr_q <= res_wr_q + 1'b1;
      if (pop)    res_rd_q <= res_rd_q + 1'b1;
      res_cnt_q <= res_cnt_q + 2'(done_q) - 2'(pop);
      cred_q    <= cred_q + 2'(start_s) - 2'(pop);
    end
  end

  // Store access, weighted accumulation, result hold
  always_ff @(posedge clk_i) begin
    if (start) op_q <= op_i;
    if (start && !op_i.is_sample) store_q[op_i.addr0] <= op_i.texel;
    if (busy_q) begin
      rd_q <= store_q[raddr];
      wt_q <= wsel[32:0];
    end
    if (rv_q) begin
      for (int k = 0; k < 3; k++) begin
        acc_q[k] <= ((rk_q == 2'd0) ? 50'd0 : acc_q[k])
                    + 50'(rd_q[47-16*k -: 16] * wt_q);
      end
    end
    if (done_q) begin
      res_q[res_wr_q].sample_red   <= acc_q[0][47:32];
      res_q[res_wr_q].sample_green <= acc_q[1][47:32];
      res_q[res_wr_q].sample_blue  <= acc_q[2][47:32];
    end
  end

  assign rsp_o = res_q[res_rd_q];
  assign rsp_valid_o = (res_cnt_q != 2'd0);
endmodule

// ----- sv/bts_checker.sv -----
// ----------------------------------------------------------------------------
// bts_checker
// Port-level checks on the sampler, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bts_checker import bts_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input req_t req_i,
  input logic req_valid_i,
  input logic req_ready_o,
  input rsp_t rsp_o,
  input logic rsp_valid_o,
  input logic rsp_ready_i
);
  `ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_o && !rsp_ready_i, rsp_valid_o && $stable(rsp_o), "result dropped or changed while stalled")
  `ASSERT_NEXT(a_front_busy, clk_i, rst_ni, req_valid_i && req_ready_o, !req_ready_o, "front accepted two requests back to back")
  `ASSERT_IMPL(a_rsp_valid_known, clk_i, rst_ni, 1'b1, !$isunknown(rsp_valid_o), "result valid is unknown")
endmodule

bind bilinear_texel_sampler bts_checker u_bts_checker (.*);
